// ===== hw/rtl/rle_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rle_pkg;

  localparam logic [3:0] RUN_LIMIT_CAP = 4'd9;
  localparam logic [3:0] MAX_RUN_RESET = 4'd9;
  localparam logic [7:0] ASCII_ZERO    = 8'd48;
  localparam int         QUEUE_DEPTH   = 2;

  // byte position within one queued command
  typedef enum logic [1:0] {
    PH_DIGIT_A = 2'd0,
    PH_SYM_A   = 2'd1,
    PH_DIGIT_B = 2'd2,
    PH_SYM_B   = 2'd3
  } phase_t;

  // one input item's worth of output: a run-break pair and/or a final flush pair
  typedef struct packed {
    logic       has_a;
    logic [3:0] a_count;
    logic [7:0] a_sym;
    logic       has_b;
    logic [3:0] b_count;
    logic [7:0] b_sym;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rle_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface rle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       is_final;

  modport source (output valid, output symbol, output is_final, input ready);
  modport sink   (input valid, input symbol, input is_final, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rle_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface rle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_item;
  logic       end_of_output;

  modport source (output valid, output out_byte, output last_of_item,
                  output end_of_output, input ready);
  modport sink   (input valid, input out_byte, input last_of_item,
                  input end_of_output, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rle_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rle_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [3:0]   cfg_wdata,
  rle_in_if.sink            in_ch,
  output logic              push_valid,
  output rle_pkg::cmd_t     push_cmd,
  input  wire logic         push_ready
);

  logic [3:0] max_run;
  logic [7:0] run_symbol, run_symbol_next;
  logic [3:0] run_count, run_count_next;
  logic [3:0] lim;
  logic       fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_run <= rle_pkg::MAX_RUN_RESET;
    end else if (cfg_we) begin
      max_run <= cfg_wdata;
    end
  end

  // clamp limit to 1..9
  always_comb begin
    if (max_run == 4'd0) begin
      lim = 4'd1;
    end else if (max_run > rle_pkg::RUN_LIMIT_CAP) begin
      lim = rle_pkg::RUN_LIMIT_CAP;
    end else begin
      lim = max_run;
    end
  end

  always_comb begin
    run_symbol_next = run_symbol;
    run_count_next  = run_count;
    push_cmd        = '0;
    if (run_count == 4'd0) begin
      run_symbol_next = in_ch.symbol;
      run_count_next  = 4'd1;
    end else if (in_ch.symbol != run_symbol || run_count >= lim) begin
      push_cmd.has_a   = 1'b1;
      push_cmd.a_count = run_count;
      push_cmd.a_sym   = run_symbol;
      run_symbol_next  = in_ch.symbol;
      run_count_next   = 4'd1;
    end else begin
      run_count_next = run_count + 4'd1;
    end
    // flush the open run, including this byte
    if (in_ch.is_final) begin
      push_cmd.has_b   = 1'b1;
      push_cmd.b_count = run_count_next;
      push_cmd.b_sym   = run_symbol_next;
      run_symbol_next  = 8'd0;
      run_count_next   = 4'd0;
    end
  end

  assign in_ch.ready = push_ready;
  assign fire        = in_ch.valid && push_ready;
  assign push_valid  = in_ch.valid && (push_cmd.has_a || push_cmd.has_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      run_symbol <= 8'd0;
      run_count  <= 4'd0;
    end else if (fire) begin
      run_symbol <= run_symbol_next;
      run_count  <= run_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rle_cmd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rle_cmd_fifo #(
  parameter int DEPTH = rle_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  input  wire rle_pkg::cmd_t push_cmd,
  output logic               push_ready,
  output logic               pop_valid,
  output rle_pkg::cmd_t      pop_cmd,
  input  wire logic          pop_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rle_pkg::cmd_t       slots [DEPTH];
  logic [PTR_W-1:0]    wr_ptr, rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                do_push, do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rle_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rle_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          pop_valid,
  input  wire rle_pkg::cmd_t pop_cmd,
  output logic               pop_ready,
  rle_out_if.source          out_ch
);

  rle_pkg::cmd_t    cur;
  logic             cur_valid;
  rle_pkg::phase_t  phase;
  logic             at_end;
  logic             out_fire;

  assign at_end   = (phase == rle_pkg::PH_SYM_B) ||
                    (phase == rle_pkg::PH_SYM_A && !cur.has_b);
  assign out_fire = out_ch.valid && out_ch.ready;
  assign pop_ready = !cur_valid || (out_fire && at_end);

  always_comb begin
    out_ch.valid         = cur_valid;
    out_ch.out_byte      = 8'd0;
    out_ch.last_of_item  = 1'b0;
    out_ch.end_of_output = 1'b0;
    unique case (phase)
      rle_pkg::PH_DIGIT_A: begin
        out_ch.out_byte = rle_pkg::ASCII_ZERO + {4'd0, cur.a_count};
      end
      rle_pkg::PH_SYM_A: begin
        out_ch.out_byte     = cur.a_sym;
        out_ch.last_of_item = !cur.has_b;
      end
      rle_pkg::PH_DIGIT_B: begin
        out_ch.out_byte = rle_pkg::ASCII_ZERO + {4'd0, cur.b_count};
      end
      rle_pkg::PH_SYM_B: begin
        out_ch.out_byte      = cur.b_sym;
        out_ch.last_of_item  = 1'b1;
        out_ch.end_of_output = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      cur <= pop_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= rle_pkg::PH_DIGIT_A;
    end else if (pop_ready) begin
      // load the next command, skipping the break pair when it has none
      cur_valid <= pop_valid;
      phase     <= pop_cmd.has_a ? rle_pkg::PH_DIGIT_A : rle_pkg::PH_DIGIT_B;
    end else if (out_fire) begin
      phase <= rle_pkg::phase_t'(phase + 2'd1);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rle_ascii_digit_encoder.sv =====
// Path: an item's first result byte goes through the command queue, then the output stage.
// Throughput: one input request per cycle while the command queue has room; the back end
// sends one output byte per cycle while out_ch.ready is high, so a command (two or four
// bytes) holds it until its last byte is taken, and input waits once the queue is full.
// Reset (synchronous, active high): clears the open run, the queue and the output stage,
// and sets max_run to 9.
`timescale 1ns / 1ps
`default_nettype none

module rle_ascii_digit_encoder #(
  parameter int QUEUE_DEPTH = rle_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_wdata,
  rle_in_if.sink          in_ch,
  rle_out_if.source       out_ch
);

  logic          push_valid, push_ready;
  rle_pkg::cmd_t push_cmd;
  logic          pop_valid, pop_ready;
  rle_pkg::cmd_t pop_cmd;

  rle_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  rle_cmd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  rle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
